// File: sv/c2sd_pkg.sv
// Shared types, constants and the month table for the calendar to serial date converter.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package c2sd_pkg;

    // Word accepted on the date channel.
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] millis;
    } date_word_t;

    // Word delivered on the serial channel.
    typedef struct packed {
        logic signed [22:0] serial_day;
        logic [31:0]        day_fraction;
        logic [2:0]         error_code;
    } serial_word_t;

    // Error codes, in the order the checks are made.
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_YEAR    = 3'd1;
    localparam logic [2:0] ERR_MONTH   = 3'd2;
    localparam logic [2:0] ERR_DAY     = 3'd3;
    localparam logic [2:0] ERR_HOUR    = 3'd4;
    localparam logic [2:0] ERR_MINUTE  = 3'd5;
    localparam logic [2:0] ERR_SECONDS = 3'd6;

    // Field limits.
    localparam logic [13:0] YEAR_FIRST     = 14'd1900;
    localparam logic [13:0] YEAR_LAST      = 14'd9999;
    localparam logic [13:0] YEAR_BEFORE    = 14'd1899;
    localparam logic [3:0]  MONTH_JAN      = 4'd1;
    localparam logic [3:0]  MONTH_FEB      = 4'd2;
    localparam logic [3:0]  MONTH_DEC      = 4'd12;
    localparam logic [4:0]  DAY_FIRST      = 5'd1;
    localparam logic [4:0]  DAY_LAST       = 5'd31;
    localparam logic [4:0]  DAY_FALSE_LEAP = 5'd29;
    localparam logic [4:0]  HOUR_LAST      = 5'd23;
    localparam logic [5:0]  MINUTE_LAST    = 6'd59;
    localparam logic [15:0] MS_PER_MINUTE  = 16'd60000;

    // Offset of the 1904 base year above 1900, in years.
    localparam logic [12:0] EPOCH_1904_OFS = 13'd4;

    // Time of day in milliseconds fits 27 bits.
    localparam int TOD_W = 27;
    localparam logic [TOD_W-1:0] TOD_MS_PER_HOUR   = 27'd3600000;
    localparam logic [TOD_W-1:0] TOD_MS_PER_MINUTE = 27'd60000;

    // Fraction of the day: floor(tod * 2^32 / 86400000) as floor(tod * RECIP / 2^44).
    // The reciprocal is rounded up; its error stays far below one step of the result.
    localparam int FRAC_SHIFT  = 44;
    localparam int RECIP_W     = 50;
    localparam int RECIP_HALF  = 25;
    localparam int FRAC_PP_W   = TOD_W + RECIP_HALF;
    localparam int FRAC_SUM_W  = TOD_W + RECIP_W;
    localparam logic [127:0] FRAC_RECIP_WIDE = ((128'd1 << 76) / 128'd86400000) + 128'd1;
    localparam logic [RECIP_W-1:0] FRAC_RECIP = RECIP_W'(FRAC_RECIP_WIDE);
    localparam logic [RECIP_HALF-1:0] FRAC_RECIP_LO = FRAC_RECIP[RECIP_HALF-1:0];
    localparam logic [RECIP_HALF-1:0] FRAC_RECIP_HI = FRAC_RECIP[RECIP_W-1:RECIP_HALF];

    // Division by 100 of values below 8400 as (x * 5243) >> 19.
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_100_SHIFT = 19;
    localparam logic [13:0] HUNDRED         = 14'd100;
    localparam logic [12:0] CENTURY_OFS     = 13'd300;

    // Serial day constants.
    localparam logic signed [22:0] SERIAL_ZERO        = 23'sd0;
    localparam logic signed [22:0] SERIAL_1899_IN_1904 = -23'sd1461;
    localparam logic signed [22:0] SERIAL_FALSE_LEAP  = 23'sd60;
    localparam logic signed [22:0] SERIAL_PRE_LEAP    = 23'sd59;
    localparam logic signed [22:0] DAYS_PER_YEAR      = 23'sd365;

    // Word held after the check stage.
    typedef struct packed {
        logic [2:0]         err;
        logic               epoch_1904;
        logic               fixed;
        logic signed [22:0] fixed_day;
        logic [12:0]        year_ofs;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [TOD_W-1:0]   tod;
    } check_word_t;

    // Word held after the multiply stage.
    typedef struct packed {
        logic [2:0]             err;
        logic                   epoch_1904;
        logic                   fixed;
        logic signed [22:0]     fixed_day;
        logic [12:0]            year_ofs;
        logic [6:0]             cent;
        logic [6:0]             cent_ofs;
        logic                   early;
        logic signed [22:0]     days;
        logic [FRAC_PP_W-1:0]   pp_lo;
        logic [FRAC_PP_W-1:0]   pp_hi;
    } mul_word_t;

    // Word held after the sum stage.
    typedef struct packed {
        logic [2:0]         err;
        logic               epoch_1904;
        logic               fixed;
        logic signed [22:0] fixed_day;
        logic signed [22:0] total;
        logic [31:0]        frac;
    } sum_word_t;

    // Days before the first of a month in a common year.
    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] days;
        case (month)
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// File: sv/c2sd_check.sv
// First pipeline stage: field checks, special dates and the time of day in milliseconds.
// Depends on c2sd_pkg.
`timescale 1ns / 1ps

module c2sd_check (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  epoch_1904,
    input  logic                  src_valid,
    input  c2sd_pkg::date_word_t  src_word,
    output logic                  dst_valid,
    output c2sd_pkg::check_word_t dst_word
);

    logic                  valid_reg;
    c2sd_pkg::check_word_t word_reg;
    c2sd_pkg::check_word_t word_next;
    logic                  zero_date;
    logic                  base_1899;
    logic [13:0]           year_diff;

    assign zero_date = (src_word.year == 14'd0) && (src_word.month == 4'd0)
                       && (src_word.day == 5'd0);
    assign base_1899 = (src_word.year == c2sd_pkg::YEAR_BEFORE)
                       && (src_word.month == c2sd_pkg::MONTH_DEC)
                       && (src_word.day == c2sd_pkg::DAY_LAST);
    assign year_diff = src_word.year - c2sd_pkg::YEAR_FIRST;

    // Checks in priority order, then the mapping of the special dates.
    always_comb
    begin
        word_next = '0;
        word_next.epoch_1904 = epoch_1904;

        if ((src_word.year < c2sd_pkg::YEAR_FIRST) && !zero_date && !base_1899)
        begin
            word_next.err = c2sd_pkg::ERR_YEAR;
        end
        else if (src_word.year > c2sd_pkg::YEAR_LAST)
        begin
            word_next.err = c2sd_pkg::ERR_YEAR;
        end
        else if ((src_word.year != 14'd0) && ((src_word.month < c2sd_pkg::MONTH_JAN)
                 || (src_word.month > c2sd_pkg::MONTH_DEC)))
        begin
            word_next.err = c2sd_pkg::ERR_MONTH;
        end
        else if ((src_word.year != 14'd0) && ((src_word.day < c2sd_pkg::DAY_FIRST)
                 || (src_word.day > c2sd_pkg::DAY_LAST)))
        begin
            word_next.err = c2sd_pkg::ERR_DAY;
        end
        else if (src_word.hour > c2sd_pkg::HOUR_LAST)
        begin
            word_next.err = c2sd_pkg::ERR_HOUR;
        end
        else if (src_word.minute > c2sd_pkg::MINUTE_LAST)
        begin
            word_next.err = c2sd_pkg::ERR_MINUTE;
        end
        else if (src_word.millis >= c2sd_pkg::MS_PER_MINUTE)
        begin
            word_next.err = c2sd_pkg::ERR_SECONDS;
        end
        else
        begin
            word_next.err = c2sd_pkg::ERR_NONE;
        end

        word_next.year_ofs  = year_diff[12:0];
        word_next.month     = src_word.month;
        word_next.day       = src_word.day;
        word_next.fixed_day = c2sd_pkg::SERIAL_ZERO;

        if (src_word.year == 14'd0)
        begin
            // A time with no date sits on the base date of the epoch.
            if (epoch_1904)
            begin
                word_next.year_ofs = c2sd_pkg::EPOCH_1904_OFS;
                word_next.month    = c2sd_pkg::MONTH_JAN;
                word_next.day      = c2sd_pkg::DAY_FIRST;
            end
            else
            begin
                word_next.fixed = 1'b1;
            end
        end
        else if (base_1899)
        begin
            word_next.fixed     = 1'b1;
            word_next.fixed_day = epoch_1904 ? c2sd_pkg::SERIAL_1899_IN_1904
                                             : c2sd_pkg::SERIAL_ZERO;
        end
        else if (!epoch_1904 && (src_word.year == c2sd_pkg::YEAR_FIRST)
                 && (src_word.month == c2sd_pkg::MONTH_FEB)
                 && (src_word.day == c2sd_pkg::DAY_FALSE_LEAP))
        begin
            // The false leap day of 1900.
            word_next.fixed     = 1'b1;
            word_next.fixed_day = c2sd_pkg::SERIAL_FALSE_LEAP;
        end

        word_next.tod = c2sd_pkg::TOD_W'(src_word.hour) * c2sd_pkg::TOD_MS_PER_HOUR
                        + c2sd_pkg::TOD_W'(src_word.minute) * c2sd_pkg::TOD_MS_PER_MINUTE
                        + c2sd_pkg::TOD_W'(src_word.millis);
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= src_valid;
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_word  = word_reg;

endmodule

// File: sv/c2sd_mul.sv
// Second pipeline stage: partial products of the day fraction, century quotients and year days.
// Depends on c2sd_pkg.
`timescale 1ns / 1ps

module c2sd_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  src_valid,
    input  c2sd_pkg::check_word_t src_word,
    output logic                  dst_valid,
    output c2sd_pkg::mul_word_t   dst_word
);

    logic                 valid_reg;
    c2sd_pkg::mul_word_t  word_reg;
    c2sd_pkg::mul_word_t  word_next;
    logic [13:0]          year_ofs_300;
    logic [25:0]          cent_prod;
    logic [26:0]          cent_ofs_prod;
    logic signed [13:0]   span;
    logic signed [13:0]   quarter;
    logic                 quarter_fix;
    logic [9:0]           date_days;

    // Quotients by 100 through the reciprocal.
    assign year_ofs_300  = 14'(src_word.year_ofs) + 14'(c2sd_pkg::CENTURY_OFS);
    assign cent_prod     = 26'(src_word.year_ofs) * 26'(c2sd_pkg::RECIP_100);
    assign cent_ofs_prod = 27'(year_ofs_300) * 27'(c2sd_pkg::RECIP_100);

    // Years since the epoch and their leap days; a span just below the 1904 epoch
    // divides by four with truncation towards zero.
    assign span = $signed({1'b0, src_word.year_ofs})
                  - (src_word.epoch_1904 ? $signed(14'(c2sd_pkg::EPOCH_1904_OFS)) : 14'sd0);
    assign quarter_fix = src_word.epoch_1904 && (src_word.year_ofs != 13'd0)
                         && (src_word.year_ofs < c2sd_pkg::EPOCH_1904_OFS);
    assign quarter = $signed({3'b000, src_word.year_ofs[12:2]})
                     - (src_word.epoch_1904 ? 14'sd1 : 14'sd0)
                     + (quarter_fix ? 14'sd1 : 14'sd0);
    assign date_days = 10'(c2sd_pkg::month_start(src_word.month)) + 10'(src_word.day);

    always_comb
    begin
        word_next            = '0;
        word_next.err        = src_word.err;
        word_next.epoch_1904 = src_word.epoch_1904;
        word_next.fixed      = src_word.fixed;
        word_next.fixed_day  = src_word.fixed_day;
        word_next.year_ofs   = src_word.year_ofs;
        word_next.cent       = 7'(cent_prod >> c2sd_pkg::RECIP_100_SHIFT);
        word_next.cent_ofs   = 7'(cent_ofs_prod >> c2sd_pkg::RECIP_100_SHIFT);
        word_next.early      = (src_word.month <= c2sd_pkg::MONTH_FEB);
        word_next.days       = 23'(span) * c2sd_pkg::DAYS_PER_YEAR + 23'(quarter)
                               + $signed({13'd0, date_days});
        word_next.pp_lo      = c2sd_pkg::FRAC_PP_W'(src_word.tod)
                               * c2sd_pkg::FRAC_PP_W'(c2sd_pkg::FRAC_RECIP_LO);
        word_next.pp_hi      = c2sd_pkg::FRAC_PP_W'(src_word.tod)
                               * c2sd_pkg::FRAC_PP_W'(c2sd_pkg::FRAC_RECIP_HI);
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= src_valid;
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_word  = word_reg;

endmodule

// File: sv/c2sd_sum.sv
// Third pipeline stage: leap year test, century terms and the sum of the fraction products.
// Depends on c2sd_pkg.
`timescale 1ns / 1ps

module c2sd_sum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                src_valid,
    input  c2sd_pkg::mul_word_t src_word,
    output logic                dst_valid,
    output c2sd_pkg::sum_word_t dst_word
);

    logic                               valid_reg;
    c2sd_pkg::sum_word_t                word_reg;
    c2sd_pkg::sum_word_t                word_next;
    logic [c2sd_pkg::FRAC_SUM_W-1:0]    frac_sum;
    logic [13:0]                        year_ofs_300;
    logic                               cent_year;
    logic                               quad_cent_year;
    logic                               leap;

    // Full product of the time of day and the reciprocal.
    assign frac_sum = {src_word.pp_hi, c2sd_pkg::RECIP_HALF'(0)}
                      + c2sd_pkg::FRAC_SUM_W'(src_word.pp_lo);

    // Leap year: divisible by four, and not a century unless divisible by 400.
    assign year_ofs_300   = 14'(src_word.year_ofs) + 14'(c2sd_pkg::CENTURY_OFS);
    assign cent_year      = (14'(src_word.year_ofs) == 14'(src_word.cent) * c2sd_pkg::HUNDRED);
    assign quad_cent_year = (year_ofs_300 == 14'(src_word.cent_ofs) * c2sd_pkg::HUNDRED)
                            && (src_word.cent_ofs[1:0] == 2'b00);
    assign leap           = (src_word.year_ofs[1:0] == 2'b00) && (!cent_year || quad_cent_year);

    always_comb
    begin
        word_next            = '0;
        word_next.err        = src_word.err;
        word_next.epoch_1904 = src_word.epoch_1904;
        word_next.fixed      = src_word.fixed;
        word_next.fixed_day  = src_word.fixed_day;
        word_next.frac       = frac_sum[c2sd_pkg::FRAC_SHIFT +: 32];
        word_next.total      = src_word.days
                               - $signed({16'd0, src_word.cent})
                               + $signed({18'd0, src_word.cent_ofs[6:2]})
                               - $signed({22'd0, leap && src_word.early});
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= src_valid;
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_word  = word_reg;

endmodule

// File: sv/c2sd_out.sv
// Last pipeline stage and output register: false leap day step, special dates and error masking.
// Depends on c2sd_pkg.
`timescale 1ns / 1ps

module c2sd_out (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic                   src_valid,
    input  c2sd_pkg::sum_word_t    src_word,
    output logic                   dst_valid,
    output c2sd_pkg::serial_word_t dst_word
);

    logic                   valid_reg;
    c2sd_pkg::serial_word_t word_reg;
    c2sd_pkg::serial_word_t word_next;
    logic                   step;

    // In the 1900 epoch every day after the false leap day is one higher.
    assign step = !src_word.epoch_1904 && (src_word.total > c2sd_pkg::SERIAL_PRE_LEAP);

    always_comb
    begin
        word_next = '0;
        if (src_word.err != c2sd_pkg::ERR_NONE)
        begin
            word_next.serial_day   = c2sd_pkg::SERIAL_ZERO;
            word_next.day_fraction = 32'd0;
            word_next.error_code   = src_word.err;
        end
        else
        begin
            word_next.serial_day   = src_word.fixed ? src_word.fixed_day
                                     : src_word.total + $signed({22'd0, step});
            word_next.day_fraction = src_word.frac;
            word_next.error_code   = c2sd_pkg::ERR_NONE;
        end
    end

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= src_valid;
        end
    end

    // Output data.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_word  = word_reg;

endmodule

// File: sv/calendar_to_serial_date_top.sv
// Calendar date and time of day to serial day number and Q0.32 day fraction.
// Calendar date and time of day in, serial day and day fraction out.
//
// Use: a date word (year, month, day, hour, minute, millis) is taken on the
// date channel when date_valid and date_ready are both high. One serial word
// (serial_day, day_fraction, error_code) leaves on the serial channel for each
// date word, in order, when serial_valid and serial_ready are both high.
// The epoch is chosen by the one-bit register written on the cfg channel
// (1 for the 1904 epoch); cfg_ready is always high. Write it only while the
// block is empty.
// A date word passes through the check, multiply, sum and output registers before
// serial_valid shows its serial word. A new word can be taken in every cycle while
// serial_ready is high, so throughput is one word per cycle; the block is a
// four-stage pipeline, and its multiply stage holds the 27 by 25 bit partial
// products of the day fraction.
// Reset clears every stage valid bit and selects the 1900 epoch. While the
// receiver holds serial_ready low, the words stay in their stages and
// date_ready falls once all four stages are full; nothing is lost or repeated.
// Depends on c2sd_pkg and the four stage modules.
`timescale 1ns / 1ps

module calendar_to_serial_date_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data,
    input  logic                   date_valid,
    output logic                   date_ready,
    input  c2sd_pkg::date_word_t   date_word,
    output logic                   serial_valid,
    input  logic                   serial_ready,
    output c2sd_pkg::serial_word_t serial_word
);

    logic                  epoch_1904_reg;
    logic                  load_check;
    logic                  load_mul;
    logic                  load_sum;
    logic                  load_out;
    logic                  check_valid;
    logic                  mul_valid;
    logic                  sum_valid;
    c2sd_pkg::check_word_t check_word;
    c2sd_pkg::mul_word_t   mul_word;
    c2sd_pkg::sum_word_t   sum_word;

    // Epoch register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_1904_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            epoch_1904_reg <= cfg_data;
        end
    end

    // A stage loads when it is empty or the stage after it moves on.
    assign load_out   = !serial_valid || serial_ready;
    assign load_sum   = !sum_valid || load_out;
    assign load_mul   = !mul_valid || load_sum;
    assign load_check = !check_valid || load_mul;
    assign date_ready = load_check;

    c2sd_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load_check),
        .epoch_1904 (epoch_1904_reg),
        .src_valid  (date_valid),
        .src_word   (date_word),
        .dst_valid  (check_valid),
        .dst_word   (check_word)
    );

    c2sd_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load_mul),
        .src_valid (check_valid),
        .src_word  (check_word),
        .dst_valid (mul_valid),
        .dst_word  (mul_word)
    );

    c2sd_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load_sum),
        .src_valid (mul_valid),
        .src_word  (mul_word),
        .dst_valid (sum_valid),
        .dst_word  (sum_word)
    );

    c2sd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load_out),
        .src_valid (sum_valid),
        .src_word  (sum_word),
        .dst_valid (serial_valid),
        .dst_word  (serial_word)
    );

endmodule
